// ===== hw/rtl/kws_pkg.sv =====
`default_nettype none

package kws_pkg;

  localparam int MAX_KEYS   = 64;
  localparam int IDX_W      = $clog2(MAX_KEYS);
  localparam int CNT_W      = 7;
  localparam int TIME_W     = 31;
  localparam int RECIP_W    = 32;
  localparam int WGT_W      = 64;
  localparam int LANE_W     = 16;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 104;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_KEY_COUNT = 1'b0;

  typedef struct packed {
    logic                 morph;
    logic [WGT_W-1:0]     end_weights;
    logic [WGT_W-1:0]     start_weights;
    logic [RECIP_W-1:0]   recip;
    logic [TIME_W-1:0]    key_time;
  } kws_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    kws_entry_t       data;
  } kws_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/keyframe_weight_sampler.sv =====
// channel   dir  handshake          payload
// in_       in   in_tvalid/tready   tdata: entry/key/weights/query, tuser: op
// out_      out  out_tvalid/tready  tdata: frame_index/weights/morph/duration
// cfg_      in   apb, pready high   key_count at byte address 0
//
// a load item writes one table entry; a query walks the key table and, when the
// selected key has morph targets, blends (one shared 33x33 multiplier, blend then 4 lanes)
// the walk takes up to MAX_KEYS/4 - 1 forward steps, then back steps through the key table,
// one table read per cycle on its single registered read port
// synchronous active-low reset clears the sequencer, key_count (to 1) and out valid
// in_tready is high only while idle; a finished result waits in the output register
`default_nettype none

module keyframe_weight_sampler (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // entry_index, key_time, recip_duration, start_weights, end_weights,
  // morph_present, query_time, zero pad
  input  wire logic [kws_pkg::IN_DATA_W-1:0]      in_tdata,
  // op
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // frame_index, blended_weights, morph_active, duration, zero pad
  output logic [kws_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [kws_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [kws_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [kws_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);
  import kws_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LAST  = 9'b000000010,
    S_FWD   = 9'b000000100,
    S_BACK  = 9'b000001000,
    S_BLEND = 9'b000010000,
    S_SAT   = 9'b000100000,
    S_LANE  = 9'b001000000,
    S_ACC   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            key_count_r;
  logic [IDX_W-1:0]            used_m1;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [IDX_W-1:0]            rd_addr;
  logic [31:0]                 query_r, query_nxt;
  logic [TIME_W-1:0]           t_r, t_nxt;
  logic [TIME_W-1:0]           last_r, last_nxt;
  logic signed [31:0]          blend_r, blend_nxt;
  logic [1:0]                  lane_r, lane_nxt;
  logic [WGT_W-1:0]            packed_r, packed_nxt;
  logic                        out_valid_r;
  logic [IDX_W-1:0]            out_frame_r;
  logic [WGT_W-1:0]            out_weights_r;
  logic                        out_morph_r;
  logic [TIME_W-1:0]           out_dur_r;
  logic                        out_load;
  logic                        in_accept;
  logic                        cfg_write;
  kws_wr_t                     wr;
  kws_entry_t                  rd_data;
  logic                        mul_en;
  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0]    prod_r;
  logic [TIME_W-1:0]           tq;
  logic signed [MUL_W-1:0]     diff;
  logic signed [PROD_W-1:0]    prod_rnd;
  logic signed [PROD_W-17:0]   quo;
  logic [31:0]                 lane_rnd;
  logic signed [LANE_W-1:0]    s_lane, e_lane;
  logic signed [LANE_W:0]      d_lane;
  logic [LANE_W-1:0]           w_lane;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_KEY_COUNT) ? CFG_DATA_W'(key_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= CNT_W'(1);
    end else if (cfg_write && cfg_paddr[2] == REG_KEY_COUNT) begin
      key_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    priority if (key_count_r == '0) begin
      used_m1 = '0;
    end else if (32'(key_count_r) > 32'(MAX_KEYS)) begin
      used_m1 = IDX_W'(MAX_KEYS - 1);
    end else begin
      used_m1 = IDX_W'(key_count_r - CNT_W'(1));
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign wr.en              = in_accept && (in_tuser == OP_LOAD)
                              && (32'(in_tdata[5:0]) < 32'(MAX_KEYS));
  assign wr.addr            = IDX_W'(in_tdata[5:0]);
  assign wr.data.key_time   = in_tdata[36:6];
  assign wr.data.recip      = in_tdata[68:37];
  assign wr.data.start_weights = in_tdata[132:69];
  assign wr.data.end_weights   = in_tdata[196:133];
  assign wr.data.morph      = in_tdata[197];

  kws_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kws_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // arithmetic around the shared multiplier
  always_comb begin
    tq       = query_r[31] ? '0 : query_r[TIME_W-1:0];
    diff     = $signed({2'b00, t_r}) - $signed({2'b00, rd_data.key_time});
    prod_rnd = prod_r + (prod_r[PROD_W-1] ? PROD_W'(16'hFFFF) : '0);
    quo      = prod_rnd[PROD_W-1:16];
    s_lane   = rd_data.start_weights[{lane_r, 4'b0000} +: LANE_W];
    e_lane   = rd_data.end_weights[{lane_r, 4'b0000} +: LANE_W];
    d_lane   = {e_lane[LANE_W-1], e_lane} - {s_lane[LANE_W-1], s_lane};
    lane_rnd = prod_r[31:0] + (prod_r[PROD_W-1] ? 32'h0000FFFF : 32'h0);
    w_lane   = s_lane + lane_rnd[31:16];
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    query_nxt  = query_r;
    t_nxt      = t_r;
    last_nxt   = last_r;
    blend_nxt  = blend_r;
    lane_nxt   = lane_r;
    packed_nxt = packed_r;
    rd_addr    = idx_r;
    mul_en     = 1'b0;
    mul_a      = MUL_W'(blend_r);
    mul_b      = MUL_W'(d_lane);
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = used_m1;
        if (in_accept && in_tuser == OP_QUERY) begin
          query_nxt = in_tdata[229:198];
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        last_nxt  = rd_data.key_time;
        t_nxt     = (tq > rd_data.key_time) ? rd_data.key_time : tq;
        idx_nxt   = used_m1 & IDX_W'(3);
        rd_addr   = idx_nxt;
        state_nxt = S_FWD;
      end
      S_FWD: begin
        if (idx_r < used_m1 && rd_data.key_time < t_r) begin
          idx_nxt = idx_r + IDX_W'(4);
          rd_addr = idx_nxt;
        end else begin
          state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        if (idx_r != '0 && t_r < rd_data.key_time) begin
          idx_nxt = idx_r - IDX_W'(1);
          rd_addr = idx_nxt;
        end else if (rd_data.morph) begin
          state_nxt = S_BLEND;
        end else begin
          packed_nxt = '0;
          state_nxt  = S_DONE;
        end
      end
      S_BLEND: begin
        mul_en    = 1'b1;
        mul_a     = $signed({1'b0, rd_data.recip});
        mul_b     = diff;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if ((&quo[PROD_W-17:31]) || !(|quo[PROD_W-17:31])) begin
          blend_nxt = quo[31:0];
        end else if (quo[PROD_W-17]) begin
          blend_nxt = 32'sh80000000;
        end else begin
          blend_nxt = 32'sh7FFFFFFF;
        end
        lane_nxt  = '0;
        state_nxt = S_LANE;
      end
      S_LANE: begin
        mul_en    = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        packed_nxt[{lane_r, 4'b0000} +: LANE_W] = w_lane;
        lane_nxt = lane_r + 2'd1;
        if (lane_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_LANE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    query_r  <= query_nxt;
    t_r      <= t_nxt;
    last_r   <= last_nxt;
    blend_r  <= blend_nxt;
    lane_r   <= lane_nxt;
    packed_r <= packed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r   <= idx_r;
      out_weights_r <= packed_r;
      out_morph_r   <= rd_data.morph;
      out_dur_r     <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_dur_r, out_morph_r, out_weights_r, 6'(out_frame_r)};

  a_fwd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FWD |-> idx_r[1:0] == used_m1[1:0])
    else $error("forward walk left its start lane");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWD || state_r == S_BACK) |-> t_r <= last_r)
    else $error("query time above last key time");

  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_morph_r) |-> out_weights_r == '0)
    else $error("plain keyframe gave nonzero weights");

  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> idx_r <= used_m1)
    else $error("selected frame beyond key count");

endmodule

`default_nettype wire

// ===== hw/rtl/kws_table.sv =====
`default_nettype none

module kws_table (
  input  wire logic                      clk,
  input  wire kws_pkg::kws_wr_t          wr,
  input  wire logic [kws_pkg::IDX_W-1:0] rd_addr,
  output kws_pkg::kws_entry_t            rd_data
);
  import kws_pkg::*;

  kws_entry_t mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kws_mul.sv =====
`default_nettype none

module kws_mul (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [kws_pkg::MUL_W-1:0]   a,
  input  wire logic signed [kws_pkg::MUL_W-1:0]   b,
  output logic signed      [kws_pkg::PROD_W-1:0]  p_r
);
  import kws_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kws_pkg::*;

  localparam int ENT_LSB = 0;
  localparam int KT_LSB  = 6;
  localparam int RC_LSB  = 37;
  localparam int SW_LSB  = 69;
  localparam int EW_LSB  = 133;
  localparam int MF_LSB  = 197;
  localparam int QT_LSB  = 198;

  localparam int FR_LSB = 0;
  localparam int BW_LSB = 6;
  localparam int MA_LSB = 70;
  localparam int DU_LSB = 71;

  localparam logic [CFG_ADDR_W-1:0] KEY_COUNT_ADDR = CFG_ADDR_W'(4 * REG_KEY_COUNT);

  localparam int TARGET_ITEMS   = 1100;
  localparam int DRAIN_CYCLES   = 48;
  localparam int HOLD_CYCLES    = 500;
  localparam int HOLD_AFTER     = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic                 op;
    logic [IN_DATA_W-1:0] data;
  } kf_item_t;

  typedef struct packed {
    logic [5:0]  frame;
    logic [63:0] weights;
    logic        morph;
    logic [30:0] duration;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // entry_index, key_time, recip_duration, start_weights, end_weights,
  // morph_present, query_time, zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // op
  logic                  in_tuser = OP_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // frame_index, blended_weights, morph_active, duration, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  keyframe_weight_sampler uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the key table and register
  logic [30:0] tbl_time [MAX_KEYS];
  logic [31:0] tbl_recip [MAX_KEYS];
  logic [63:0] tbl_start [MAX_KEYS];
  logic [63:0] tbl_end [MAX_KEYS];
  logic        tbl_morph [MAX_KEYS];
  logic [6:0]  count_reg = 7'd1;

  // what the stimulus side has planned, ahead of acceptance
  logic [30:0] plan_time [MAX_KEYS];
  logic [6:0]  plan_count = 7'd1;

  kf_item_t pending_items[$];
  sample_t  expected_samples[$];

  int errors = 0;
  int n_queued = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_checked = 0;
  int n_settings = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= 30) begin
      $display("ERROR at %0t ns: %s got %h expected %h", $realtime, what, got, want);
    end
  endtask

  function automatic int unsigned keys_in_use(logic [6:0] c);
    if (c == 0) return 1;
    if (c > MAX_KEYS) return MAX_KEYS;
    return c;
  endfunction

  function automatic sample_t sample_keyframes(logic [31:0] qtime);
    int unsigned used;
    int unsigned last_t;
    int unsigned t;
    int unsigned idx;
    longint      diff;
    longint      blend;
    longint      term;
    longint      w;
    int          s;
    int          e;
    sample_t     r;
    used   = keys_in_use(count_reg);
    last_t = tbl_time[used-1];
    t      = qtime[31] ? 0 : qtime;
    if (t > last_t) t = last_t;
    idx = (used - 1) & 3;
    while (idx < used - 1 && tbl_time[idx] < t) idx += 4;
    while (idx != 0 && t < tbl_time[idx]) idx--;
    r.frame    = idx[5:0];
    r.weights  = '0;
    r.morph    = tbl_morph[idx];
    r.duration = last_t[30:0];
    if (tbl_morph[idx]) begin
      diff  = longint'(t) - longint'(tbl_time[idx]);
      blend = (longint'(tbl_recip[idx]) * diff) / 65536;
      if (blend > 64'sd2147483647) blend = 64'sd2147483647;
      if (blend < -64'sd2147483648) blend = -64'sd2147483648;
      for (int lane = 0; lane < 4; lane++) begin
        s = $signed(tbl_start[idx][16*lane +: 16]);
        e = $signed(tbl_end[idx][16*lane +: 16]);
        term = (blend * longint'(e - s)) / 65536;
        w = longint'(s) + term;
        r.weights[16*lane +: 16] = w[15:0];
      end
    end
    return r;
  endfunction

  function automatic void absorb_item(kf_item_t it);
    logic [5:0] ent;
    if (it.op == OP_LOAD) begin
      ent = it.data[ENT_LSB +: 6];
      tbl_time[ent]  = it.data[KT_LSB +: 31];
      tbl_recip[ent] = it.data[RC_LSB +: 32];
      tbl_start[ent] = it.data[SW_LSB +: 64];
      tbl_end[ent]   = it.data[EW_LSB +: 64];
      tbl_morph[ent] = it.data[MF_LSB];
      n_loads++;
    end else begin
      expected_samples.push_back(sample_keyframes(it.data[QT_LSB +: 32]));
      n_queries++;
    end
  endfunction

  // sender: bursts of random length, random gaps between them
  kf_item_t cur_item;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) absorb_item(cur_item);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_tdata  <= cur_item.data;
          in_tuser  <= cur_item.op;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(10, 40);
            else gap_left = $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, one long hold-off
  logic [15:0] stall_pat = 16'hFFFF;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          taken = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = 16'hFFFF;
            1: stall_pat = 16'h5555;
            2: stall_pat = 16'($urandom) & 16'($urandom);
            default: stall_pat = 16'($urandom);
          endcase
        end
        out_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata[63:0], '0);
      end else begin
        want = expected_samples.pop_front();
        n_checked++;
        if (out_tdata[FR_LSB +: 6] !== want.frame)
          report_mismatch("frame_index", out_tdata[FR_LSB +: 6], want.frame);
        if (out_tdata[BW_LSB +: 64] !== want.weights)
          report_mismatch("blended_weights", out_tdata[BW_LSB +: 64], want.weights);
        if (out_tdata[MA_LSB] !== want.morph)
          report_mismatch("morph_active", out_tdata[MA_LSB], want.morph);
        if (out_tdata[DU_LSB +: 31] !== want.duration)
          report_mismatch("duration", out_tdata[DU_LSB +: 31], want.duration);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] random_payload();
    logic [255:0] raw;
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < 8; i++) raw[32*i +: 32] = $urandom;
    d = raw[IN_DATA_W-1:0];
    d[IN_DATA_W-1:QT_LSB+32] = '0;
    return d;
  endfunction

  function automatic logic [63:0] random_weights();
    logic [63:0] w;
    for (int lane = 0; lane < 4; lane++) begin
      case ($urandom_range(0, 5))
        0: w[16*lane +: 16] = 16'h8000;
        1: w[16*lane +: 16] = 16'h7FFF;
        2: w[16*lane +: 16] = 16'($urandom_range(0, 2000));
        default: w[16*lane +: 16] = 16'($urandom);
      endcase
    end
    return w;
  endfunction

  task automatic push_load(logic [5:0] ent, logic [30:0] kt, logic [31:0] recip,
                           logic [63:0] sw, logic [63:0] ew, logic mf);
    logic [IN_DATA_W-1:0] d;
    d = random_payload();
    d[ENT_LSB +: 6]  = ent;
    d[KT_LSB +: 31]  = kt;
    d[RC_LSB +: 32]  = recip;
    d[SW_LSB +: 64]  = sw;
    d[EW_LSB +: 64]  = ew;
    d[MF_LSB]        = mf;
    plan_time[ent]   = kt;
    pending_items.push_back('{op: OP_LOAD, data: d});
    n_queued++;
  endtask

  task automatic push_query(logic [31:0] qtime);
    logic [IN_DATA_W-1:0] d;
    d = random_payload();
    d[QT_LSB +: 32] = qtime;
    pending_items.push_back('{op: OP_QUERY, data: d});
    n_queued++;
  endtask

  function automatic logic [31:0] pick_query_time();
    int unsigned used;
    int unsigned last_t;
    logic [31:0] q;
    used   = keys_in_use(plan_count);
    last_t = plan_time[used-1];
    case ($urandom_range(0, 9))
      0: q = {1'b1, 31'($urandom)};
      1: q = {1'b0, 31'($urandom)};
      2: q = {1'b0, plan_time[$urandom_range(0, used - 1)]};
      default: q = $urandom_range(0, last_t);
    endcase
    return q;
  endfunction

  // ascending key times, recip matched to each key's length most of the time
  task automatic reload_sorted(int unsigned n);
    logic [30:0] kt;
    logic [32:0] quot;
    logic [31:0] recip;
    int unsigned step_max;
    int unsigned stride;
    kt = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom_range(0, 32'h2_0000));
    step_max = ($urandom_range(0, 4) == 0) ? 32'h0100_0000 : 32'h0004_0000;
    for (int unsigned i = 0; i < n; i++) begin
      stride = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_max);
      if (stride == 0 || $urandom_range(0, 4) == 0) begin
        recip = $urandom;
      end else begin
        quot  = 33'h1_0000_0000 / stride;
        recip = quot[32] ? 32'hFFFF_FFFF : quot[31:0];
      end
      push_load(6'(i), kt, recip, random_weights(), random_weights(),
                $urandom_range(0, 4) != 0);
      kt = kt + 31'(stride);
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_tvalid || expected_samples.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_count(logic [6:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= KEY_COUNT_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    count_reg   = value;
    plan_count  = value;
    n_settings++;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== CFG_DATA_W'(value))
      report_mismatch("key_count readback", cfg_prdata, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    int          kc_list[10] = '{64, 0, 127, 1, 5, 64, 2, 100, 13, 33};
    int          phase_no;
    int          kc;
    int unsigned nq;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single key: clamp below zero and above the last key, then a plain key
    push_load(6'd0, 31'h0010_0000, 32'h0001_0000, 64'h1234_0000_7FFF_8000,
              64'hEDCB_0000_8000_7FFF, 1'b1);
    push_query(32'h8000_0000);
    push_query(32'h7FFF_FFFF);
    push_query(32'h0000_0000);
    push_load(6'd0, 31'h0010_0000, 32'h0001_0000, 64'h1234_0000_7FFF_8000,
              64'hEDCB_0000_8000_7FFF, 1'b0);
    push_query(32'h0008_0000);
    wait_idle();

    // four keys, saturating blends both ways, zero recip, widest key time
    push_load(6'd0, 31'h4000_0000, 32'hFFFF_FFFF, 64'h8000_7FFF_0001_FFFF,
              64'h7FFF_8000_FFFF_0001, 1'b1);
    push_load(6'd1, 31'h5000_0000, 32'h0000_0000, 64'h1111_2222_3333_4444,
              64'h8000_8000_8000_8000, 1'b1);
    push_load(6'd2, 31'h6000_0000, 32'hFFFF_FFFF, 64'h8000_7FFF_0000_1000,
              64'h7FFF_8000_0000_F000, 1'b1);
    push_load(6'd3, 31'h7FFF_FFFF, 32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
              64'h0000_0000_0000_0000, 1'b1);
    wait_idle();
    write_key_count(7'd4);
    push_query(32'h0000_0000);
    push_query(32'h5800_0000);
    push_query(32'h7000_0000);
    push_query(32'h7FFF_FFFF);
    push_query(32'hFFFF_FFFF);

    phase_no = 0;
    while (n_queued < TARGET_ITEMS) begin
      wait_idle();
      if (phase_no < 10) kc = kc_list[phase_no];
      else if ($urandom_range(0, 9) == 0) kc = 0;
      else if ($urandom_range(0, 9) == 0) kc = $urandom_range(65, 127);
      else kc = $urandom_range(1, 64);
      write_key_count(7'(kc));
      if (phase_no == 0 || $urandom_range(0, 9) < 6) reload_sorted(keys_in_use(7'(kc)));
      nq = $urandom_range(20, 60);
      for (int unsigned i = 0; i < nq; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_load(6'($urandom), 31'($urandom), $urandom, {$urandom, $urandom},
                    {$urandom, $urandom}, 1'($urandom));
        else
          push_query(pick_query_time());
      end
      phase_no++;
    end

    wait_idle();
    $display("checked %0d results from %0d queries, %0d loads", n_checked, n_queries, n_loads);
    $display("%0d key_count settings incl. 0, 1, 64, 127; sorted and scrambled tables",
             n_settings);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
